// ===== sv/sal_pkg.sv =====
// Package for the sorted array linked list: sizes, mode and status codes,
// and the structs passed between the sequencer and the slot memories.
// No dependencies.
`default_nettype none

package sal_pkg;

    localparam int DEPTH   = 16;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int MODE_W  = 2;
    localparam int KEY_W   = 31;
    localparam int PAY_W   = 32;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_MISS = 2'd2;

    // write and read commands toward the slot memories
    typedef struct packed {
        logic [SLOT_W-1:0] rd_addr;
        logic              kp_we;
        logic [SLOT_W-1:0] kp_addr;
        logic [KEY_W-1:0]  key_wdata;
        logic [PAY_W-1:0]  pay_wdata;
        logic              link_we;
        logic [SLOT_W-1:0] link_addr;
        logic [SLOT_W-1:0] link_wdata;
    } mem_cmd_t;

    // registered read data of one slot
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic [SLOT_W-1:0] link;
    } mem_rd_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [PAY_W-1:0]   found_payload;
        logic [ENTRY_W-1:0] entry_count;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/sal_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on sal_pkg for field widths.
`default_nettype none

interface sal_req_if;
    logic                       valid;
    logic                       ready;
    logic [sal_pkg::MODE_W-1:0] mode;
    logic [sal_pkg::KEY_W-1:0]  key;
    logic [sal_pkg::PAY_W-1:0]  payload;

    modport source (output valid, output mode, output key, output payload, input ready);
    modport sink (input valid, input mode, input key, input payload, output ready);
endinterface

interface sal_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [sal_pkg::STAT_W-1:0]  status;
    logic [sal_pkg::PAY_W-1:0]   found_payload;
    logic [sal_pkg::ENTRY_W-1:0] entry_count;

    modport source (output valid, output status, output found_payload, output entry_count,
                    input ready);
    modport sink (input valid, input status, input found_payload, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/sal_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module sal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/sal_ctrl.sv =====
// Sequencer: walks the linked list one slot per cycle with a shared key
// comparator and patches links, head, tail, used bits and count.
// Depends on sal_pkg and sal_req_if.
`default_nettype none

module sal_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    sal_req_if.sink                 req,
    output sal_pkg::mem_cmd_t       mem_cmd,
    input  wire sal_pkg::mem_rd_t   mem_rd,
    output logic                    res_valid,
    input  wire logic               res_take,
    output sal_pkg::res_t           res
);

    localparam int SLOT_W = sal_pkg::SLOT_W;
    localparam int CNT_W  = sal_pkg::CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_LINK2 = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [sal_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [sal_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [sal_pkg::PAY_W-1:0]    pay_reg, pay_next;
    logic [sal_pkg::DEPTH-1:0]    used_reg, used_next;
    logic [SLOT_W-1:0]            head_reg, head_next;
    logic [SLOT_W-1:0]            tail_reg, tail_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [SLOT_W-1:0]            cur_reg, cur_next;
    logic [SLOT_W-1:0]            prev_reg, prev_next;
    logic                         first_reg, first_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [SLOT_W-1:0]            w2_addr_reg, w2_addr_next;
    logic [sal_pkg::STAT_W-1:0]   status_reg, status_next;
    logic [sal_pkg::PAY_W-1:0]    found_reg, found_next;
    logic [SLOT_W-1:0]            free_slot;
    logic                         key_less;
    logic                         key_match;
    logic                         at_end;

    // lowest numbered free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = sal_pkg::DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign key_less  = key_reg < mem_rd.key;
    assign key_match = key_reg == mem_rd.key;
    assign at_end    = mem_rd.link == head_reg;

    assign req.ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res.status        = status_reg;
    assign res.found_payload = found_reg;
    assign res.entry_count   = sal_pkg::ENTRY_W'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        used_next    = used_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        first_next   = first_reg;
        slot_next    = slot_reg;
        w2_addr_next = w2_addr_reg;
        status_next  = status_reg;
        found_next   = found_reg;

        mem_cmd.kp_we      = 1'b0;
        mem_cmd.kp_addr    = free_slot;
        mem_cmd.key_wdata  = key_reg;
        mem_cmd.pay_wdata  = pay_reg;
        mem_cmd.link_we    = 1'b0;
        mem_cmd.link_addr  = slot_reg;
        mem_cmd.link_wdata = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = req.mode;
                    key_next   = req.key;
                    pay_next   = req.payload;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                status_next = sal_pkg::STATUS_OK;
                found_next  = '0;
                case (mode_reg)
                    sal_pkg::MODE_INSERT:
                    begin
                        if (count_reg >= CNT_W'(sal_pkg::DEPTH))
                        begin
                            status_next = sal_pkg::STATUS_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            slot_next            = free_slot;
                            used_next[free_slot] = 1'b1;
                            count_next           = count_reg + CNT_W'(1);
                            mem_cmd.kp_we        = 1'b1;
                            if (count_reg == '0)
                            begin
                                mem_cmd.link_we    = 1'b1;
                                mem_cmd.link_addr  = free_slot;
                                mem_cmd.link_wdata = free_slot;
                                head_next          = free_slot;
                                tail_next          = free_slot;
                                state_next         = S_DONE;
                            end
                            else
                            begin
                                cur_next   = head_reg;
                                first_next = 1'b1;
                                state_next = S_WALK;
                            end
                        end
                    end

                    sal_pkg::MODE_REMOVE, sal_pkg::MODE_FIND:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = sal_pkg::STATUS_MISS;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cur_next   = head_reg;
                            first_next = 1'b1;
                            state_next = S_WALK;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // read data holds the slot at cur_reg
            S_WALK:
            begin
                case (mode_reg)
                    sal_pkg::MODE_INSERT:
                    begin
                        if (key_less)
                        begin
                            mem_cmd.link_we    = 1'b1;
                            mem_cmd.link_addr  = slot_reg;
                            mem_cmd.link_wdata = cur_reg;
                            w2_addr_next       = first_reg ? tail_reg : prev_reg;
                            if (first_reg)
                            begin
                                head_next = slot_reg;
                            end
                            state_next = S_LINK2;
                        end
                        else if (at_end)
                        begin
                            // append behind the tail
                            mem_cmd.link_we    = 1'b1;
                            mem_cmd.link_addr  = slot_reg;
                            mem_cmd.link_wdata = head_reg;
                            w2_addr_next       = cur_reg;
                            tail_next          = slot_reg;
                            state_next         = S_LINK2;
                        end
                        else
                        begin
                            prev_next  = cur_reg;
                            cur_next   = mem_rd.link;
                            first_next = 1'b0;
                        end
                    end

                    sal_pkg::MODE_REMOVE:
                    begin
                        if (key_match)
                        begin
                            used_next[cur_reg] = 1'b0;
                            count_next         = count_reg - CNT_W'(1);
                            state_next         = S_DONE;
                            if (first_reg)
                            begin
                                if (count_reg == CNT_W'(1))
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                end
                                else
                                begin
                                    mem_cmd.link_we    = 1'b1;
                                    mem_cmd.link_addr  = tail_reg;
                                    mem_cmd.link_wdata = mem_rd.link;
                                    head_next          = mem_rd.link;
                                end
                            end
                            else
                            begin
                                mem_cmd.link_we    = 1'b1;
                                mem_cmd.link_addr  = prev_reg;
                                mem_cmd.link_wdata = mem_rd.link;
                                if (cur_reg == tail_reg)
                                begin
                                    tail_next = prev_reg;
                                end
                            end
                        end
                        else if (at_end)
                        begin
                            status_next = sal_pkg::STATUS_MISS;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            prev_next  = cur_reg;
                            cur_next   = mem_rd.link;
                            first_next = 1'b0;
                        end
                    end

                    sal_pkg::MODE_FIND:
                    begin
                        if (key_match)
                        begin
                            found_next = mem_rd.payload;
                            state_next = S_DONE;
                        end
                        else if (at_end)
                        begin
                            status_next = sal_pkg::STATUS_MISS;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cur_next   = mem_rd.link;
                            first_next = 1'b0;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // second link patch of an insert: predecessor points at the new slot
            S_LINK2:
            begin
                mem_cmd.link_we    = 1'b1;
                mem_cmd.link_addr  = w2_addr_reg;
                mem_cmd.link_wdata = slot_reg;
                state_next         = S_DONE;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        mem_cmd.rd_addr = cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        first_reg   <= first_next;
        slot_reg    <= slot_next;
        w2_addr_reg <= w2_addr_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
    end

    a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == count_reg)
        else $error("used bits disagree with entry count");

    a_head_used: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> used_reg[head_reg] && used_reg[tail_reg])
        else $error("head or tail slot is free while list is not empty");

    a_walk_on_used: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK && mode_reg != sal_pkg::MODE_INSERT |-> used_reg[cur_reg])
        else $error("walk visits a free slot");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_START)
        else $error("accepted item did not start");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(sal_pkg::DEPTH))
        else $error("entry count above table depth");

endmodule

`default_nettype wire

// ===== sv/sorted_array_linked_list.sv =====
// Sorted linked list held in a table of DEPTH slots (sal_pkg::DEPTH).
// Requests arrive on req (mode, key, payload); one result per request leaves
// on rsp (status, found_payload, entry_count). Both are valid/ready channels,
// an item moves at a clock edge with valid and ready high.
// Modes: insert places the entry in the lowest free slot, after equal keys;
// remove unlinks the first matching entry; find returns its payload.
// Sequence: an accepted item goes through S_START, then S_WALK for each list
// slot visited by the walk (none for an empty table, an insert into a full or
// empty table or the unused mode; at most DEPTH), then S_LINK2 for an insert
// that links into the list, then S_DONE. The walk reads one slot per cycle from
// the key/payload/link memories through a single registered read port.
// req.ready is high only while the sequencer is idle, so one request is in
// work at a time; it is taken again once the result moves into the output
// register, even while that register still waits on rsp.ready.
// When the receiver stalls, the finished result waits in the sequencer and
// then in the output register; nothing is dropped.
// Reset (rst_n low, asynchronous) frees every slot and clears head, tail and
// count; slot memories are not cleared, data read from free slots is never used.
// Depends on sal_pkg, sal_if, sal_ram, sal_ctrl.
`default_nettype none

module sorted_array_linked_list (
    input  wire logic clk,
    input  wire logic rst_n,
    sal_req_if.sink   req,
    sal_rsp_if.source rsp
);

    sal_pkg::mem_cmd_t mem_cmd;
    sal_pkg::mem_rd_t  mem_rd;
    sal_pkg::res_t     res;
    sal_pkg::res_t     out_reg;
    logic              res_valid;
    logic              res_take;
    logic              out_valid_reg;

    sal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_cmd   (mem_cmd),
        .mem_rd    (mem_rd),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    sal_ram #(.WIDTH(sal_pkg::KEY_W), .DEPTH(sal_pkg::DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (mem_cmd.kp_we),
        .waddr (mem_cmd.kp_addr),
        .wdata (mem_cmd.key_wdata),
        .raddr (mem_cmd.rd_addr),
        .rdata (mem_rd.key)
    );

    sal_ram #(.WIDTH(sal_pkg::PAY_W), .DEPTH(sal_pkg::DEPTH)) u_pay_ram (
        .clk   (clk),
        .we    (mem_cmd.kp_we),
        .waddr (mem_cmd.kp_addr),
        .wdata (mem_cmd.pay_wdata),
        .raddr (mem_cmd.rd_addr),
        .rdata (mem_rd.payload)
    );

    sal_ram #(.WIDTH(sal_pkg::SLOT_W), .DEPTH(sal_pkg::DEPTH)) u_link_ram (
        .clk   (clk),
        .we    (mem_cmd.link_we),
        .waddr (mem_cmd.link_addr),
        .wdata (mem_cmd.link_wdata),
        .raddr (mem_cmd.rd_addr),
        .rdata (mem_rd.link)
    );

    // output register takes a result when empty or being drained
    assign res_take = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.found_payload = out_reg.found_payload;
    assign rsp.entry_count   = out_reg.entry_count;

endmodule

`default_nettype wire

// ===== tb/sv/tb_sorted_array_linked_list.sv =====
// Testbench for sorted_array_linked_list: directed and random insert/remove/find
// items checked against an in-bench list predictor inside a small scoreboard class.
// Depends on sal_pkg, sal_if and the RTL of the block.

module tb_sorted_array_linked_list;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = sal_pkg::DEPTH;
    localparam int SLOT_W  = sal_pkg::SLOT_W;
    localparam int MODE_W  = sal_pkg::MODE_W;
    localparam int KEY_W   = sal_pkg::KEY_W;
    localparam int PAY_W   = sal_pkg::PAY_W;
    localparam int STAT_W  = sal_pkg::STAT_W;
    localparam int ENTRY_W = sal_pkg::ENTRY_W;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;   // unused code, block does nothing
    localparam logic [KEY_W-1:0]  KEY_MAX   = {KEY_W{1'b1}};
    localparam logic [PAY_W-1:0]  PAY_MAX   = {PAY_W{1'b1}};
    localparam int KEY_POOL_SIZE = 24;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 105;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LIMIT_CYCLES  = 400000;

    class list_scoreboard;
        bit [KEY_W-1:0]  key_of [DEPTH];
        bit [PAY_W-1:0]  pay_of [DEPTH];
        bit [SLOT_W-1:0] next_of [DEPTH];
        bit              used [DEPTH];
        bit [SLOT_W-1:0] head_idx;
        bit [SLOT_W-1:0] tail_idx;
        int              held;
        sal_pkg::res_t   expected_q[$];
        int errors;
        int checked;
        int n_insert, n_remove, n_find, n_none, n_full, n_miss;

        function int pending();
            return expected_q.size();
        endfunction

        // advance the list copy by one accepted request and queue its result
        function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                   logic [PAY_W-1:0] pay);
            sal_pkg::res_t r;
            bit [SLOT_W-1:0] slot;
            bit [SLOT_W-1:0] cur;
            bit [SLOT_W-1:0] nx;
            r.status = sal_pkg::STATUS_OK;
            r.found_payload = '0;
            case (mode)
                sal_pkg::MODE_INSERT:
                begin
                    n_insert++;
                    if (held >= DEPTH)
                    begin
                        r.status = sal_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        slot = '0;
                        for (int i = DEPTH - 1; i >= 0; i--)
                            if (!used[i]) slot = SLOT_W'(i);
                        key_of[slot] = key;
                        pay_of[slot] = pay;
                        used[slot] = 1'b1;
                        if (held == 0)
                        begin
                            next_of[slot] = slot;
                            head_idx = slot;
                            tail_idx = slot;
                        end
                        else if (key < key_of[head_idx])
                        begin
                            next_of[slot] = head_idx;
                            next_of[tail_idx] = slot;
                            head_idx = slot;
                        end
                        else
                        begin
                            // goes after every equal key: stop at first larger key or wrap
                            cur = head_idx;
                            for (int i = 0; i < DEPTH; i++)
                            begin
                                nx = next_of[cur];
                                if (nx == head_idx)
                                begin
                                    next_of[cur] = slot;
                                    next_of[slot] = head_idx;
                                    tail_idx = slot;
                                    break;
                                end
                                if (key < key_of[nx])
                                begin
                                    next_of[slot] = nx;
                                    next_of[cur] = slot;
                                    break;
                                end
                                cur = nx;
                            end
                        end
                        held++;
                    end
                end
                sal_pkg::MODE_REMOVE:
                begin
                    n_remove++;
                    if (held == 0)
                    begin
                        r.status = sal_pkg::STATUS_MISS;
                    end
                    else if (key_of[head_idx] == key)
                    begin
                        used[head_idx] = 1'b0;
                        if (held == 1)
                        begin
                            head_idx = '0;
                            tail_idx = '0;
                        end
                        else
                        begin
                            next_of[tail_idx] = next_of[head_idx];
                            head_idx = next_of[head_idx];
                        end
                        held--;
                    end
                    else
                    begin
                        r.status = sal_pkg::STATUS_MISS;
                        cur = head_idx;
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            nx = next_of[cur];
                            if (nx == head_idx) break;
                            if (key_of[nx] == key)
                            begin
                                next_of[cur] = next_of[nx];
                                used[nx] = 1'b0;
                                if (nx == tail_idx) tail_idx = cur;
                                held--;
                                r.status = sal_pkg::STATUS_OK;
                                break;
                            end
                            cur = nx;
                        end
                    end
                end
                sal_pkg::MODE_FIND:
                begin
                    n_find++;
                    r.status = sal_pkg::STATUS_MISS;
                    cur = head_idx;
                    for (int i = 0; i < held; i++)
                    begin
                        if (key_of[cur] == key)
                        begin
                            r.status = sal_pkg::STATUS_OK;
                            r.found_payload = pay_of[cur];
                            break;
                        end
                        cur = next_of[cur];
                    end
                end
                default: n_none++;
            endcase
            if (r.status == sal_pkg::STATUS_FULL) n_full++;
            if (r.status == sal_pkg::STATUS_MISS) n_miss++;
            r.entry_count = ENTRY_W'(held);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic [PAY_W-1:0] found_payload,
                                   logic [ENTRY_W-1:0] entry_count);
            sal_pkg::res_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d payload %h count %0d",
                         $time, status, found_payload, entry_count);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (status !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                errors++;
            end
            if (found_payload !== e.found_payload)
            begin
                $display("%0t: found_payload expected %h actual %h", $time,
                         e.found_payload, found_payload);
                errors++;
            end
            if (entry_count !== e.entry_count)
            begin
                $display("%0t: entry_count expected %0d actual %0d", $time,
                         e.entry_count, entry_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   tight;          // no idling on either side while set
    bit   hold_request;   // asks the receiver for one long hold-off
    int   cycles;
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    list_scoreboard sb = new;

    sal_req_if req_ch ();
    sal_rsp_if rsp_ch ();

    sorted_array_linked_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("sorted_array_linked_list test failed");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int idle_gap();
        int r;
        if (tight) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 70)
            return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        return KEY_W'($urandom);
    endfunction

    function automatic logic [PAY_W-1:0] pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return PAY_MAX;
        return $urandom;
    endfunction

    task automatic send_item(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                             logic [PAY_W-1:0] pay);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.mode    <= mode;
        req_ch.key     <= key;
        req_ch.payload <= pay;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(mode, key, pay);
    endtask

    // receiver: checks each accepted result, stalls at random
    initial
    begin : rsp_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.status, rsp_ch.found_payload, rsp_ch.entry_count);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 30) stall_left = idle_gap();
            end
        end
    end

    initial
    begin : stimulus
        logic [MODE_W-1:0] mode;
        int ins_pct;
        int rem_pct;
        int r;
        req_ch.valid   = 1'b0;
        req_ch.mode    = sal_pkg::MODE_INSERT;
        req_ch.key     = '0;
        req_ch.payload = '0;
        rst_n          = 1'b0;
        tight          = 1'b0;
        hold_request   = 1'b0;

        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        for (int i = 2; i < KEY_POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, unused mode
        send_item(sal_pkg::MODE_FIND, 31'd5, '0);
        send_item(sal_pkg::MODE_REMOVE, 31'd5, '0);
        send_item(MODE_NONE, KEY_MAX, PAY_MAX);
        // fill to the brim: extremes, equal keys, new head, then middle inserts
        send_item(sal_pkg::MODE_INSERT, KEY_MAX, PAY_MAX);
        send_item(sal_pkg::MODE_INSERT, 31'd5, 32'h1111_1111);
        send_item(sal_pkg::MODE_INSERT, 31'd5, 32'h2222_2222);
        send_item(sal_pkg::MODE_INSERT, '0, '0);
        for (int i = 0; i < DEPTH - 4; i++)
            send_item(sal_pkg::MODE_INSERT, KEY_W'(100 - 7 * i), $urandom);
        send_item(sal_pkg::MODE_INSERT, 31'd6, 32'hdead_beef);   // table full
        send_item(sal_pkg::MODE_FIND, 31'd5, '0);
        send_item(sal_pkg::MODE_FIND, KEY_MAX, '0);              // match at the tail
        send_item(sal_pkg::MODE_REMOVE, 31'd5, '0);
        send_item(sal_pkg::MODE_FIND, 31'd5, '0);                // second of the equal keys
        send_item(sal_pkg::MODE_REMOVE, '0, '0);                 // head
        send_item(sal_pkg::MODE_REMOVE, KEY_MAX, '0);            // tail
        send_item(sal_pkg::MODE_REMOVE, 31'd1234567, '0);        // missing key

        for (int phase = 0; phase < PHASES; phase++)
        begin
            tight = (phase == 2 || phase == 7);
            if (phase == 4) hold_request = 1'b1;
            if (phase == 6)
            begin
                // sender pauses until everything has come back
                req_ch.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
            end
            case (phase % 4)
                0:
                begin
                    ins_pct = 60;   // drives into full
                    rem_pct = 15;
                end
                1:
                begin
                    ins_pct = 20;   // drains toward empty
                    rem_pct = 55;
                end
                2:
                begin
                    ins_pct = 35;
                    rem_pct = 30;
                end
                default:
                begin
                    ins_pct = 25;
                    rem_pct = 20;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3) mode = MODE_NONE;
                else if (r < 3 + ins_pct) mode = sal_pkg::MODE_INSERT;
                else if (r < 3 + ins_pct + rem_pct) mode = sal_pkg::MODE_REMOVE;
                else mode = sal_pkg::MODE_FIND;
                send_item(mode, pick_key(), pick_payload());
            end
        end
        req_ch.valid <= 1'b0;
        tight = 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d inserts (%0d into a full table), %0d removes, %0d finds, %0d idle",
                 sb.n_insert, sb.n_full, sb.n_remove, sb.n_find, sb.n_none);
        $display("%0d results checked, %0d misses expected, %0d mismatches",
                 sb.checked, sb.n_miss, sb.errors);
        if (sb.errors == 0)
            $display("sorted_array_linked_list test passed");
        else
            $display("sorted_array_linked_list test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sal_pkg.sv
sv/sal_if.sv
sv/sal_ram.sv
sv/sal_ctrl.sv
sv/sorted_array_linked_list.sv
tb/sv/tb_sorted_array_linked_list.sv
